FILE: rtl/mtu_pkg.sv
// ----------------------------------------------------------------------------
// mtu_pkg
// Shared types and constants for the matrix times upper triangular unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtu_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int IDX_W       = 6;   // row / column field width
    localparam int VAL_W       = 16;  // Q8.8 element
    localparam int PROD_W      = 32;  // Q16.16 single product
    localparam int SUM_W       = 38;  // Q16.16 exact sum of up to 64 terms
    localparam int SIZE_W      = 7;
    localparam int IN_DATA_W   = 48;  // 44 bits used
    localparam int OUT_DATA_W  = 48;  // 44 bits used

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // one multiply-accumulate term handed from sequencer to datapath
    typedef struct packed {
        logic             valid;
        logic             first;    // first term of a column
        logic             last;     // last term of a column
        logic             row_end;  // last term of the whole row
        logic [IDX_W-1:0] col;
    } t_issue;

    typedef struct packed {
        logic pipe_busy;   // terms still in flight
        logic final_busy;  // a column sum in flight, or output word stuck
    } t_mac_status;

endpackage

`default_nettype wire

FILE: rtl/mtu_store.sv
// ----------------------------------------------------------------------------
// mtu_store
// Element memories for M and U: one write port shared by both, one
// registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module mtu_store #(
    parameter int AW = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [mtu_pkg::VAL_W-1:0] i_wleft,
    input  wire logic [mtu_pkg::VAL_W-1:0] i_wright,
    input  wire logic [AW-1:0]             i_raddr_left,
    input  wire logic [AW-1:0]             i_raddr_right,
    output logic      [mtu_pkg::VAL_W-1:0] o_rleft,
    output logic      [mtu_pkg::VAL_W-1:0] o_rright
);
    import mtu_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [VAL_W-1:0] r_left_mem  [DEPTH];
    logic [VAL_W-1:0] r_right_mem [DEPTH];
    logic [VAL_W-1:0] r_rleft;
    logic [VAL_W-1:0] r_rright;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_left_mem[i_waddr]  <= i_wleft;
            r_right_mem[i_waddr] <= i_wright;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rleft  <= r_left_mem[i_raddr_left];
        r_rright <= r_right_mem[i_raddr_right];
    end

    assign o_rleft  = r_rleft;
    assign o_rright = r_rright;

endmodule

`default_nettype wire

FILE: rtl/mtu_mac.sv
// ----------------------------------------------------------------------------
// mtu_mac
// Multiply-accumulate datapath: tag alignment with the memory read,
// product register, accumulator and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtu_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mtu_pkg::t_issue             i_issue,
    input  wire logic [mtu_pkg::VAL_W-1:0]   i_left,
    input  wire logic [mtu_pkg::VAL_W-1:0]   i_right,
    output mtu_pkg::t_mac_status             o_status,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [mtu_pkg::SUM_W-1:0]   o_sum,
    output logic      [mtu_pkg::IDX_W-1:0]   o_col,
    output logic                             o_last
);
    import mtu_pkg::*;

    t_issue             r_s1;
    t_issue             r_s2;
    logic [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]   r_acc;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    logic [IDX_W-1:0]   r_out_col;
    logic               r_out_last;
    logic [SUM_W-1:0]   n_sum;
    logic [SUM_W-1:0]   prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
        end
    end

    // memory data lines up with r_s1
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'($signed(i_left) * $signed(i_right));
    end

    assign prod_ext = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_sum    = (r_s2.first ? '0 : r_acc) + prod_ext;

    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            r_acc <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s2.valid && r_s2.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2.valid && r_s2.last) begin
            r_out_sum  <= n_sum;
            r_out_col  <= r_s2.col;
            r_out_last <= r_s2.row_end;
        end
    end

    assign o_status.pipe_busy  = r_s1.valid || r_s2.valid;
    assign o_status.final_busy = (r_s1.valid && r_s1.last) || (r_s2.valid && r_s2.last)
                                 || (r_out_valid && !i_ready);

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;
    assign o_col   = r_out_col;
    assign o_last  = r_out_last;

    // a column sum must never land on an unread output word
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2.valid && r_s2.last) |-> !(r_out_valid && !i_ready))
        else $error("column sum overwrites pending output word");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2.valid && r_s2.last) |=> r_out_valid)
        else $error("column sum not presented");

    a_first_before_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2.valid && r_s2.row_end) |-> r_s2.last)
        else $error("row end not on a column end");

endmodule

`default_nettype wire

FILE: rtl/mtu_seq.sv
// ----------------------------------------------------------------------------
// mtu_seq
// Sequencer: holds the size register, decodes input words and walks the
// column / term loops of a compute, one memory read pair per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mtu_seq #(
    parameter int MAX_DIM = mtu_pkg::MAX_DIM_DEF,
    parameter int IW      = $clog2(MAX_DIM)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wen,
    input  wire logic [mtu_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_op,
    input  wire logic [mtu_pkg::IDX_W-1:0]    i_row,
    input  wire logic [mtu_pkg::IDX_W-1:0]    i_col,
    input  wire mtu_pkg::t_mac_status         i_status,
    output logic                              o_we,
    output logic      [2*IW-1:0]              o_waddr,
    output logic      [2*IW-1:0]              o_raddr_left,
    output logic      [2*IW-1:0]              o_raddr_right,
    output mtu_pkg::t_issue                   o_issue
);
    import mtu_pkg::*;

    localparam logic [SIZE_W-1:0] DIM = SIZE_W'(MAX_DIM);

    t_state          r_state, n_state;
    logic [IW-1:0]   r_last_idx;
    logic [IW-1:0]   r_row, n_row;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic [SIZE_W-1:0] cfg_n;
    logic            accept;
    logic            row_ok;
    logic            col_ok;
    logic            term_last;
    logic            col_last;
    logic            stall;
    t_op             op;

    assign op     = t_op'(i_op);
    assign accept = i_valid && o_ready;
    assign row_ok = {1'b0, i_row} < DIM;
    assign col_ok = {1'b0, i_col} < DIM;

    // size 0 acts as 1, above MAX_DIM as MAX_DIM
    always_comb begin
        cfg_n = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_n = SIZE_W'(1);
        end else if (i_cfg_wdata > DIM) begin
            cfg_n = DIM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= IW'(MAX_DIM - 1);
        end else if (i_cfg_wen) begin
            r_last_idx <= IW'(cfg_n - SIZE_W'(1));
        end
    end

    assign o_we    = accept && (op == OP_LOAD) && row_ok && col_ok;
    assign o_waddr = {i_row[IW-1:0], i_col[IW-1:0]};

    assign term_last = (r_k == r_last_idx);
    assign col_last  = (r_j == r_last_idx);
    // a column's final term waits until its sum has a free output slot
    assign stall     = term_last && i_status.final_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_j   <= n_j;
        r_k   <= n_k;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_j     = r_j;
        n_k     = r_k;
        o_ready = 1'b0;
        o_issue = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = !i_status.pipe_busy;
                if (accept && (op == OP_COMPUTE) && row_ok) begin
                    n_row   = i_row[IW-1:0];
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    o_issue.valid   = 1'b1;
                    o_issue.first   = (r_k == '0);
                    o_issue.last    = term_last;
                    o_issue.row_end = term_last && col_last;
                    o_issue.col     = IDX_W'(r_j);
                    if (term_last) begin
                        n_k = '0;
                        n_j = r_j + IW'(1);
                        if (col_last) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_raddr_left  = {r_row, r_k};
    assign o_raddr_right = {r_k, r_j};

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_issue.valid)
        else $error("term issued while idle");

    a_final_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_issue.valid && o_issue.last) |-> !i_status.final_busy)
        else $error("column end issued without output slot");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == OP_COMPUTE) && row_ok) |=> (r_state == ST_RUN))
        else $error("compute word did not start a row");

endmodule

`default_nettype wire

FILE: rtl/matrix_times_upper_triangular_unit.sv
// ----------------------------------------------------------------------------
// matrix_times_upper_triangular_unit
// Computes one row of C = M * U per compute word, Q8.8 in, exact Q16.16 out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser selects the operation, 0 load, 1 compute.
//   A load word writes M[row][column] and U[row][column] together.
//   A compute word names row r and yields n output words C[r][0..n-1] in
//   column order, tlast on column n-1. Rows at or above MAX_DIM yield nothing.
//   Size n is written on i_cfg_wen / i_cfg_wdata while the unit is idle.
// Throughput:
//   One multiply-accumulate per cycle while no column end is stalled, M and U
//   each read from one memory port. A column's final term waits while the
//   previous column's sum is still in the pipeline or its output word is
//   unread. Loads are taken back to back.
//   A new input word is taken only once the running compute has issued all
//   its terms and the MAC pipeline is empty.
// Reset: clears control and sets n to MAX_DIM; memories keep old contents
//   and are valid only where written.
// Stall: the output word is held while m_axis_tready is low; the sequencer
//   then pauses at the next column end until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_times_upper_triangular_unit #(
    parameter int MAX_DIM = mtu_pkg::MAX_DIM_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wen,
    input  wire logic [mtu_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // row[5:0], column[11:6], left_value[27:12], right_value[43:28], zeros
    input  wire logic [mtu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation[0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // product_value[37:0], out_column[43:38], zeros
    output logic      [mtu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import mtu_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 2 * IW;

    logic [IDX_W-1:0] in_row;
    logic [IDX_W-1:0] in_col;
    logic [VAL_W-1:0] in_left;
    logic [VAL_W-1:0] in_right;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr_left;
    logic [AW-1:0]    raddr_right;
    logic [VAL_W-1:0] rd_left;
    logic [VAL_W-1:0] rd_right;
    t_issue           issue;
    t_mac_status      status;
    logic [SUM_W-1:0] out_sum;
    logic [IDX_W-1:0] out_col;

    assign in_row   = s_axis_tdata[5:0];
    assign in_col   = s_axis_tdata[11:6];
    assign in_left  = s_axis_tdata[27:12];
    assign in_right = s_axis_tdata[43:28];

    mtu_seq #(
        .MAX_DIM (MAX_DIM),
        .IW      (IW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_row         (in_row),
        .i_col         (in_col),
        .i_status      (status),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_raddr_left  (raddr_left),
        .o_raddr_right (raddr_right),
        .o_issue       (issue)
    );

    mtu_store #(
        .AW (AW)
    ) u_store (
        .i_clk         (i_clk),
        .i_we          (we),
        .i_waddr       (waddr),
        .i_wleft       (in_left),
        .i_wright      (in_right),
        .i_raddr_left  (raddr_left),
        .i_raddr_right (raddr_right),
        .o_rleft       (rd_left),
        .o_rright      (rd_right)
    );

    mtu_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_left   (rd_left),
        .i_right  (rd_right),
        .o_status (status),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_sum    (out_sum),
        .o_col    (out_col),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-SUM_W-IDX_W){1'b0}}, out_col, out_sum};

endmodule

`default_nettype wire

FILE: tb/sv/matrix_times_upper_triangular_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_times_upper_triangular_unit_tb
// Self-checking bench for the C = M * U row unit.
// The bench keeps its own copy of both element stores and the size register.
// Every compute word it sends is turned into the expected C row. Each output
// word is checked against that row, field by field and in order. A short
// directed table covers the extremes and a zero size. Random phases follow
// at several small sizes, with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_times_upper_triangular_unit_tb;

    import mtu_pkg::*;

    localparam int DIM       = MAX_DIM_DEF;
    localparam int PHASE_LEN = 11;

    typedef struct packed {
        logic [SUM_W-1:0] value;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_c_elem;

    typedef struct {
        logic [SIZE_W-1:0] size;
        t_op               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  lv;
        logic [VAL_W-1:0]  rv;
        bit                typed;   // fixed expectation, size acts as 1
        longint            val;
    } t_dir_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [SIZE_W-1:0]     i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // row[5:0], column[11:6], left_value[27:12], right_value[43:28], zeros
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // operation[0]
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // product_value[37:0], out_column[43:38], zeros
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // shadow of the block's state
    logic signed [VAL_W-1:0] m_store [DIM][DIM];
    logic signed [VAL_W-1:0] u_store [DIM][DIM];
    bit                      written [DIM][DIM];
    logic [SIZE_W-1:0]       dim_cfg = SIZE_W'(DIM);

    t_c_elem c_row_q [$];

    bit          src_quiet = 1'b0;
    bit          sink_quiet = 1'b0;
    int unsigned sink_hold = 0;
    int unsigned mismatches = 0;
    int unsigned n_words = 0;
    int unsigned n_loads = 0;
    int unsigned n_computes = 0;

    // kept small: every compute needs its whole operand block written first
    logic [SIZE_W-1:0] sweep [8] = '{7'd3, 7'd1, 7'd5, 7'd2, 7'd0, 7'd4, 7'd5, 7'd2};

    t_dir_step dir_steps [17] = '{
        '{7'd0, OP_LOAD,    6'd0,  6'd0,  16'h8000, 16'h8000, 1'b0, 0},
        '{7'd0, OP_COMPUTE, 6'd0,  6'd63, 16'h7FFF, 16'h7FFF, 1'b1, 1073741824},
        '{7'd0, OP_LOAD,    6'd0,  6'd0,  16'h7FFF, 16'h8000, 1'b0, 0},
        '{7'd0, OP_COMPUTE, 6'd0,  6'd0,  16'h0000, 16'h0000, 1'b1, -1073709056},
        '{7'd0, OP_LOAD,    6'd63, 6'd0,  16'h7FFF, 16'h7FFF, 1'b0, 0},
        '{7'd0, OP_COMPUTE, 6'd63, 6'd0,  16'h0000, 16'h0000, 1'b1, -1073709056},
        '{7'd1, OP_LOAD,    6'd0,  6'd0,  16'hFFFF, 16'h0001, 1'b0, 0},
        '{7'd1, OP_COMPUTE, 6'd63, 6'd21, 16'hFFFF, 16'h0000, 1'b1, 32767},
        '{7'd1, OP_COMPUTE, 6'd0,  6'd42, 16'h0000, 16'hFFFF, 1'b1, -1},
        '{7'd1, OP_LOAD,    6'd63, 6'd63, 16'h8000, 16'h7FFF, 1'b0, 0},
        '{7'd1, OP_LOAD,    6'd0,  6'd63, 16'h0100, 16'hFF00, 1'b0, 0},
        '{7'd2, OP_LOAD,    6'd0,  6'd1,  16'h8000, 16'h7FFF, 1'b0, 0},
        '{7'd2, OP_LOAD,    6'd1,  6'd0,  16'h7FFF, 16'h8000, 1'b0, 0},
        '{7'd2, OP_LOAD,    6'd1,  6'd1,  16'h8000, 16'h8000, 1'b0, 0},
        '{7'd2, OP_COMPUTE, 6'd1,  6'd0,  16'h0000, 16'h0000, 1'b0, 0},
        '{7'd2, OP_COMPUTE, 6'd0,  6'd0,  16'h0000, 16'h0000, 1'b0, 0},
        '{7'd2, OP_COMPUTE, 6'd63, 6'd0,  16'h0000, 16'h0000, 1'b0, 0}
    };

    matrix_times_upper_triangular_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // size 0 runs as 1, anything above the store runs as the full store
    function automatic int unsigned eff_dim();
        if (dim_cfg == 0) return 1;
        if (dim_cfg > DIM) return DIM;
        return dim_cfg;
    endfunction

    // Q8.8 element, leaning on the extremes now and then
    function automatic logic [VAL_W-1:0] pick_q88();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // one row of C = M * U, full sum including U's lower triangle
    function automatic void predict_c_row(input logic [IDX_W-1:0] r);
        int unsigned n;
        longint      acc;
        t_c_elem     e;
        n = eff_dim();
        for (int unsigned j = 0; j < n; j++) begin
            acc = 0;
            for (int unsigned k = 0; k < n; k++)
                acc += longint'(m_store[r][k]) * longint'(u_store[k][j]);
            e.value = acc[SUM_W-1:0];
            e.col   = IDX_W'(j);
            e.last  = (j == n - 1);
            c_row_q.push_back(e);
        end
    endfunction

    task automatic send_word(input t_op op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] lv,
                             input logic [VAL_W-1:0] rv, input bit typed,
                             input longint typed_val);
        int unsigned gap;
        t_c_elem     e;
        gap = src_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W-44){1'b0}}, rv, lv, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            m_store[row][col] = lv;
            u_store[row][col] = rv;
            written[row][col] = 1'b1;
            n_loads++;
        end else begin
            if (typed) begin
                e.value = typed_val[SUM_W-1:0];
                e.col   = '0;
                e.last  = 1'b1;
                c_row_q.push_back(e);
            end else begin
                predict_c_row(row);
            end
            n_computes++;
        end
    endtask

    // a compute reads M[r][0..n-1] and all of U[0..n-1][0..n-1]: load any gaps
    task automatic cover_operands(input logic [IDX_W-1:0] r);
        int unsigned n;
        n = eff_dim();
        for (int unsigned k = 0; k < n; k++)
            if (!written[r][k])
                send_word(OP_LOAD, r, IDX_W'(k), pick_q88(), pick_q88(), 1'b0, 0);
        for (int unsigned k = 0; k < n; k++)
            for (int unsigned j = 0; j < n; j++)
                if (!written[k][j])
                    send_word(OP_LOAD, IDX_W'(k), IDX_W'(j), pick_q88(), pick_q88(),
                              1'b0, 0);
    endtask

    task automatic do_compute(input logic [IDX_W-1:0] r);
        cover_operands(r);
        send_word(OP_COMPUTE, r, IDX_W'($urandom), pick_q88(), pick_q88(), 1'b0, 0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (c_row_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] v);
        wait_drained();
        // a trailing load may still be writing
        repeat (8) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        dim_cfg = v;
    endtask

    // output side: hold tready low for a drawn number of cycles before each word
    always @(posedge i_clk) begin : sink_pace
        int unsigned h;
        if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= (sink_hold == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            h = sink_quiet ? 0 : $urandom_range(0, 14);
            sink_hold     <= h;
            m_axis_tready <= (h == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : c_word_check
        t_c_elem got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[SUM_W-1:0];
            got.col   = m_axis_tdata[SUM_W +: IDX_W];
            got.last  = m_axis_tlast;
            n_words++;
            if (c_row_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %0d column %0d last %0b",
                             $signed(got.value), got.col, got.last);
            end else begin
                want = c_row_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want %0d col %0d last %0b,",
                                  " got %0d col %0d last %0b"},
                                 $signed(want.value), want.col, want.last,
                                 $signed(got.value), got.col, got.last);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned kind;
        int unsigned hold_at;
        int unsigned spins;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].size != dim_cfg) set_size(dir_steps[i].size);
            if (dir_steps[i].op == OP_COMPUTE) cover_operands(dir_steps[i].row);
            send_word(dir_steps[i].op, dir_steps[i].row, dir_steps[i].col,
                      dir_steps[i].lv, dir_steps[i].rv, dir_steps[i].typed,
                      dir_steps[i].val);
        end

        foreach (sweep[p]) begin
            set_size(sweep[p]);
            n          = eff_dim();
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            hold_at    = $urandom_range(0, PHASE_LEN - 1);
            for (int unsigned it = 0; it < PHASE_LEN; it++) begin
                if (it == hold_at) wait_drained();
                kind = $urandom_range(0, 19);
                if (kind < 9)
                    send_word(OP_LOAD, IDX_W'($urandom_range(0, n - 1)),
                              IDX_W'($urandom_range(0, n - 1)), pick_q88(), pick_q88(),
                              1'b0, 0);
                else if (kind < 18)
                    do_compute(IDX_W'($urandom_range(0, n - 1)));
                else if (kind == 18)
                    send_word(OP_LOAD, IDX_W'($urandom), IDX_W'($urandom),
                              pick_q88(), pick_q88(), 1'b0, 0);
                else
                    do_compute(IDX_W'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        sink_quiet = 1'b0;
        spins = 0;
        while (c_row_q.size() != 0 && spins < 20000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (32) @(posedge i_clk);

        if (c_row_q.size() != 0)
            $display("%0d result words never arrived", c_row_q.size());
        $display("Ran %0d loads and %0d row computes, %0d words checked, %0d bad",
                 n_loads, n_computes, n_words, mismatches);
        $display("Sizes covered: 0, 1, 2, 3, 4 and 5, with extreme Q8.8 operands");
        if (mismatches == 0 && c_row_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
